>>> rtl/lsh_pkg.sv
// ----------------------------------------------------------------------------
// lsh_pkg: shared types and constants of the log-scale histogram
// Bucket geometry, opcodes and the edge table. The edge table is built at
// elaboration time with exact integer arithmetic.
// ----------------------------------------------------------------------------
package lsh_pkg;

  // Decade range and subdivisions per decade of the edge table
  localparam int MIN_EXP          = -15;
  localparam int MAX_EXP          = 1;
  localparam int STEPS_PER_DECADE = 5;

  localparam int TOTAL_SCALES = (MAX_EXP - MIN_EXP + 1) * STEPS_PER_DECADE;
  localparam int NUM_EDGES    = TOTAL_SCALES + 1;
  localparam int NUM_BUCKETS  = TOTAL_SCALES + 4;
  localparam int BUCKET_BITS  = 7;
  localparam int TOP_BUCKET   = TOTAL_SCALES + 3;

  // Opcodes; the unused code behaves as a read
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  localparam logic [63:0] INF_BITS = 64'h7FF0_0000_0000_0000;

  // Wide integer used only while building the edge table
  localparam int BIG_W = 1024;
  typedef logic [BIG_W-1:0] big_t;

  typedef logic [63:0] edge_arr_t [NUM_EDGES];

  // Bit length of a wide integer (0 for zero)
  function automatic int big_bits(input big_t a);
    int b;
    b = 0;
    for (int st = BIG_W / 2; st >= 1; st = st / 2) begin
      if ((a >> (b + st)) != '0) b = b + st;
    end
    if (a == '0) return 0;
    return b + 1;
  endfunction

  // True when value(p)^(2*STEPS_PER_DECADE) > 10^nexp; five holds 5^|nexp|
  function automatic bit above_edge(input logic [63:0] p, input int nexp,
                                    input big_t five);
    logic [10:0] ex;
    logic [52:0] m;
    int          e;
    int          s;
    int          lb;
    int          rb;
    big_t        mb;
    big_t        l;
    big_t        r;
    ex = p[62:52];
    m  = {1'b0, p[51:0]};
    if (ex == 11'd0) begin
      e = -1074;
    end else begin
      m[52] = 1'b1;
      e     = int'(ex) - 1075;
    end
    mb = big_t'(m);
    l  = mb;
    for (int i = 1; i < 2 * STEPS_PER_DECADE; i++) l = l * mb;
    if (nexp < 0) begin
      l = l * five;
      r = big_t'(1);
    end else begin
      r = five;
    end
    s  = 2 * STEPS_PER_DECADE * e - nexp;
    lb = big_bits(l) + s;
    rb = big_bits(r);
    if (lb != rb) return (lb > rb);
    if (s >= 0) l = l << s;
    else        r = r << (-s);
    return (l > r);
  endfunction

  // Each edge: smallest binary64 pattern above 10^(MIN_EXP+(k-2.5)/STEPS_PER_DECADE)
  function automatic edge_arr_t build_edges();
    edge_arr_t   t;
    big_t        five;
    int          nexp;
    int          a;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    for (int k = 0; k < NUM_EDGES; k++) begin
      nexp = 2 * STEPS_PER_DECADE * MIN_EXP + 2 * k - 5;
      a    = (nexp < 0) ? -nexp : nexp;
      five = big_t'(1);
      for (int j = 0; j < a; j++) five = five * big_t'(5);
      lo = 64'd0;
      hi = INF_BITS;
      for (int it = 0; it < 64; it++) begin
        if (hi - lo > 64'd1) begin
          mid = lo + ((hi - lo) >> 1);
          if (above_edge(mid, nexp, five)) hi = mid;
          else                             lo = mid;
        end
      end
      t[k] = hi;
    end
    return t;
  endfunction

  localparam edge_arr_t EDGE_TAB = build_edges();

endpackage

>>> rtl/log_scale_histogram.sv
// ----------------------------------------------------------------------------
// log_scale_histogram: logarithmic histogram of binary64 samples
// Add bins a sample magnitude into a log-spaced bucket and bumps its count,
// the sample total and the peak count; read reports one bucket; clear zeroes.
// ----------------------------------------------------------------------------
// One word is accepted every cycle while the result side keeps up, and its
// result passes through the input register, the bucket memory read register
// and the result register. A stalled result holds the stages behind it.
// The bucket memory is read when a word leaves the input register and written
// when its result is registered; a one-entry forward register covers the
// single write that lands between those two points, so back-to-back adds to
// one bucket run at full rate. Bucket validity lives in flip-flops, so reset
// and clear take effect at once with no sweep. Counts saturate at
// 2^COUNT_BITS-1 and the count outputs carry their low 32 bits. The edge table
// is fixed at build time in the package.
module log_scale_histogram #(
  parameter int COUNT_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       opcode,
  input  logic [63:0]                      sample_bits,
  input  logic [lsh_pkg::BUCKET_BITS-1:0]  read_bucket,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [lsh_pkg::BUCKET_BITS-1:0]  bucket,
  output logic [31:0]                      bucket_count,
  output logic [31:0]                      sample_total,
  output logic [31:0]                      peak_count
);
  import lsh_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Low 32 bits of a count, zero extended for narrow counts
  function automatic logic [31:0] low_word(input logic [COUNT_BITS-1:0] x);
    logic [63:0] w;
    w = 64'(x);
    return w[31:0];
  endfunction

  // Handshake
  logic in_accept;
  logic s1_adv;
  logic s2_adv;
  logic out_take;

  // Stage 1: input register
  logic                   s1_valid;
  logic [1:0]             s1_op;
  logic [63:0]            s1_mag;
  logic [BUCKET_BITS-1:0] s1_rd;

  // Stage 2: memory read register
  logic                   s2_valid;
  logic [1:0]             s2_op;
  logic [BUCKET_BITS-1:0] s2_bucket;
  logic                   s2_in_range;
  logic [COUNT_BITS-1:0]  s2_rd_data;
  logic                   s2_rd_vld;

  // Bucket store and its valid bits
  logic [COUNT_BITS-1:0]  mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] vld;

  // Most recent committed write
  logic                   fwd_valid;
  logic                   fwd_clear;
  logic [BUCKET_BITS-1:0] fwd_addr;
  logic [COUNT_BITS-1:0]  fwd_data;

  // Running totals
  logic [COUNT_BITS-1:0]  total_count;
  logic [COUNT_BITS-1:0]  max_count;

  assign out_take  = out_valid && !out_stall;
  assign s2_adv    = s2_valid && (!out_valid || !out_stall);
  assign s1_adv    = s1_valid && (!s2_valid || s2_adv);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op  <= opcode;
      s1_mag <= {1'b0, sample_bits[62:0]};
      s1_rd  <= read_bucket;
    end
  end

  // Parallel edge compare: count of edges at or below the magnitude
  logic [NUM_EDGES-1:0]   s1_pass;
  logic [BUCKET_BITS-1:0] s1_pass_cnt;
  logic [BUCKET_BITS-1:0] s1_add_bucket;
  logic [BUCKET_BITS-1:0] s1_bucket;
  logic                   s1_in_range;
  logic [BUCKET_BITS-1:0] s1_addr;

  always_comb begin
    for (int k = 0; k < NUM_EDGES; k++) begin
      s1_pass[k] = (EDGE_TAB[k] <= s1_mag);
    end
    s1_pass_cnt = BUCKET_BITS'($countones(s1_pass));
  end

  // Bucket select: below all edges, past all edges, or count plus one
  always_comb begin
    if (s1_pass_cnt == '0) begin
      s1_add_bucket = '0;
    end else if (s1_pass_cnt == BUCKET_BITS'(NUM_EDGES)) begin
      s1_add_bucket = BUCKET_BITS'(TOP_BUCKET);
    end else begin
      s1_add_bucket = s1_pass_cnt + BUCKET_BITS'(1);
    end
  end

  always_comb begin
    case (s1_op)
      OP_ADD:   s1_bucket = s1_add_bucket;
      OP_CLEAR: s1_bucket = '0;
      default:  s1_bucket = s1_rd;
    endcase
    s1_in_range = (s1_bucket < BUCKET_BITS'(NUM_BUCKETS));
    s1_addr     = s1_in_range ? s1_bucket : '0;
  end

  // Stage 2 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_adv || (s2_valid && !s2_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_op       <= s1_op;
      s2_bucket   <= s1_bucket;
      s2_in_range <= s1_in_range;
      s2_rd_vld   <= vld[s1_addr];
    end
  end

  // Count update for the word in stage 2
  logic                  commit_add;
  logic                  commit_clear;
  logic [COUNT_BITS-1:0] old_count;
  logic [COUNT_BITS-1:0] new_count;
  logic [COUNT_BITS-1:0] total_next;
  logic [COUNT_BITS-1:0] max_next;

  assign commit_add   = s2_adv && (s2_op == OP_ADD);
  assign commit_clear = s2_adv && (s2_op == OP_CLEAR);

  always_comb begin
    if (fwd_valid && fwd_clear) begin
      old_count = '0;
    end else if (fwd_valid && (fwd_addr == s2_bucket)) begin
      old_count = fwd_data;
    end else if (s2_rd_vld) begin
      old_count = s2_rd_data;
    end else begin
      old_count = '0;
    end
    new_count  = (old_count != COUNT_MAX) ? old_count + COUNT_BITS'(1) : old_count;
    total_next = (total_count != COUNT_MAX) ? total_count + COUNT_BITS'(1)
                                            : total_count;
    max_next   = (new_count > max_count) ? new_count : max_count;
  end

  // Bucket memory: read on entry to stage 2, written on commit
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_rd_data <= mem[s1_addr];
    end
    if (commit_add) begin
      mem[s2_bucket] <= new_count;
    end
  end

  // Valid bits: clear drops all at once
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (commit_clear) begin
      vld <= '0;
    end else if (commit_add) begin
      vld[s2_bucket] <= 1'b1;
    end
  end

  // Forward register tracks the latest write to the store
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      fwd_clear <= 1'b0;
    end else if (commit_clear) begin
      fwd_valid <= 1'b1;
      fwd_clear <= 1'b1;
    end else if (commit_add) begin
      fwd_valid <= 1'b1;
      fwd_clear <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_add) begin
      fwd_addr <= s2_bucket;
      fwd_data <= new_count;
    end
  end

  // Sample total and peak
  always_ff @(posedge clk) begin
    if (rst) begin
      total_count <= '0;
      max_count   <= '0;
    end else if (commit_clear) begin
      total_count <= '0;
      max_count   <= '0;
    end else if (commit_add) begin
      total_count <= total_next;
      max_count   <= max_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2_adv || (out_valid && !out_take);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      case (s2_op)
        OP_ADD: begin
          bucket       <= s2_bucket;
          bucket_count <= low_word(new_count);
          sample_total <= low_word(total_next);
          peak_count   <= low_word(max_next);
        end
        OP_CLEAR: begin
          bucket       <= '0;
          bucket_count <= '0;
          sample_total <= '0;
          peak_count   <= '0;
        end
        default: begin
          bucket       <= s2_bucket;
          bucket_count <= s2_in_range ? low_word(old_count) : 32'd0;
          sample_total <= low_word(total_count);
          peak_count   <= low_word(max_count);
        end
      endcase
    end
  end

endmodule
